>>> rtl/mfr_pkg.sv
// Shared types and constants for the Manchester frame receiver.
// No dependencies; imported by every module of the receiver.
`default_nettype none

package mfr_pkg;

    // frame layout
    localparam int unsigned MAX_FRAME_BYTES = 261;
    localparam int unsigned BYTE_COUNT_W    = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [BYTE_COUNT_W-1:0] BYTE_COUNT_SAT =
        BYTE_COUNT_W'(MAX_FRAME_BYTES + 1);
    localparam logic [BYTE_COUNT_W-1:0] BYTE_COUNT_MAX =
        BYTE_COUNT_W'(MAX_FRAME_BYTES);
    localparam logic [BYTE_COUNT_W-1:0] DEST_INDEX = BYTE_COUNT_W'(2);
    localparam logic [BYTE_COUNT_W-1:0] LEN_INDEX  = BYTE_COUNT_W'(3);
    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
    localparam logic [3:0] FRAME_OVERHEAD = 4'd6;

    // register reset values
    localparam logic [7:0]  NODE_ADDRESS_RST = 8'h28;
    localparam logic [15:0] HALF_BIT_RST     = 16'd700;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NODE_ADDRESS   = 2'd0,
        CFG_HALF_BIT_THRESHOLD = 2'd1
    } cfg_idx_t;

    typedef enum logic {
        OP_EDGE  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef struct packed {
        logic [7:0]  node_address;
        logic [15:0] half_bit_threshold;
    } cfg_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] edge_time;
        logic        line_level;
    } in_item_t;

    typedef struct packed {
        logic       data_edge;
        logic       bit_value;
        logic       byte_done;
        logic [7:0] byte_value;
        logic [8:0] byte_index;
        logic       message_ready;
    } out_item_t;

endpackage

`default_nettype wire

>>> rtl/mfr_cfg_regs.sv
// Configuration registers of the Manchester frame receiver.
// Depends on mfr_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module mfr_cfg_regs
    import mfr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                        cfg
);

    logic [7:0]  node_address_reg;
    logic [7:0]  node_address_next;
    logic [15:0] half_bit_reg;
    logic [15:0] half_bit_next;

    // register write decode
    always_comb
    begin
        node_address_next = node_address_reg;
        half_bit_next     = half_bit_reg;
        if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_NODE_ADDRESS:       node_address_next = wr_data[7:0];
                CFG_HALF_BIT_THRESHOLD: half_bit_next     = wr_data[15:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= NODE_ADDRESS_RST;
            half_bit_reg     <= HALF_BIT_RST;
        end
        else
        begin
            node_address_reg <= node_address_next;
            half_bit_reg     <= half_bit_next;
        end
    end

    assign cfg.node_address       = node_address_reg;
    assign cfg.half_bit_threshold = half_bit_reg;

endmodule

`default_nettype wire

>>> rtl/mfr_bit_decoder.sv
// Receiver state and decode step for one item.
// Depends on mfr_pkg; produces the result item combinationally.
`default_nettype none

module mfr_bit_decoder
    import mfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic                    awaiting_reg, awaiting_next;
    logic                    last_level_reg, last_level_next;
    logic [31:0]             last_time_reg, last_time_next;
    logic [2:0]              bit_count_reg, bit_count_next;
    logic [BYTE_COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]              shift_reg, shift_next;
    logic [7:0]              dest_reg, dest_next;
    logic [7:0]              length_reg, length_next;
    logic                    ready_reg, ready_next;

    logic [31:0] elapsed;
    logic        is_data;
    logic        bit_val;
    logic [7:0]  shifted;
    logic        byte_end;
    logic        accept_byte;
    logic [9:0]  needed;
    logic        addr_match;

    // edge classification
    assign elapsed = item.edge_time - last_time_reg;
    assign is_data = (awaiting_reg && !item.line_level)
                     || (elapsed > {16'd0, cfg.half_bit_threshold});
    assign bit_val = item.line_level && !last_level_reg;
    assign shifted = {shift_reg[6:0], bit_val};
    assign byte_end    = (bit_count_reg == 3'd7);
    assign accept_byte = byte_end && (byte_count_reg <= BYTE_COUNT_MAX);

    // ready check on the updated frame state
    assign needed     = 10'(FRAME_OVERHEAD) + 10'(length_next);
    assign addr_match = (dest_next == cfg.node_address) || (dest_next == BROADCAST_ADDR);

    // next state and result
    always_comb
    begin
        awaiting_next   = awaiting_reg;
        last_level_next = last_level_reg;
        last_time_next  = last_time_reg;
        bit_count_next  = bit_count_reg;
        byte_count_next = byte_count_reg;
        shift_next      = shift_reg;
        dest_next       = dest_reg;
        length_next     = length_reg;
        ready_next      = ready_reg;
        result          = '0;

        if (item.operation == OP_CLEAR)
        begin
            awaiting_next   = 1'b1;
            last_level_next = 1'b1;
            last_time_next  = '0;
            bit_count_next  = '0;
            byte_count_next = '0;
            shift_next      = '0;
            dest_next       = '0;
            length_next     = '0;
            ready_next      = 1'b0;
        end
        else
        begin
            if (is_data)
            begin
                awaiting_next    = 1'b0;
                result.data_edge = 1'b1;
                result.bit_value = bit_val;
                bit_count_next   = bit_count_reg + 3'd1;
                last_time_next   = item.edge_time;
                shift_next       = byte_end ? 8'd0 : shifted;
                if (accept_byte)
                begin
                    result.byte_done  = 1'b1;
                    result.byte_value = shifted;
                    result.byte_index = 9'(byte_count_reg);
                    if (byte_count_reg == DEST_INDEX)
                    begin
                        dest_next = shifted;
                    end
                    if (byte_count_reg == LEN_INDEX)
                    begin
                        length_next = shifted;
                    end
                    byte_count_next = byte_count_reg + BYTE_COUNT_W'(1);
                end
            end
            last_level_next = item.line_level;
            if ((byte_count_next > DEST_INDEX) && addr_match
                && (10'(byte_count_next) >= needed))
            begin
                ready_next = 1'b1;
            end
            result.message_ready = ready_next;
        end
    end

    // state registers, updated only when an item is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg   <= 1'b1;
            last_level_reg <= 1'b1;
            last_time_reg  <= '0;
            bit_count_reg  <= '0;
            byte_count_reg <= '0;
            shift_reg      <= '0;
            dest_reg       <= '0;
            length_reg     <= '0;
            ready_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            awaiting_reg   <= awaiting_next;
            last_level_reg <= last_level_next;
            last_time_reg  <= last_time_next;
            bit_count_reg  <= bit_count_next;
            byte_count_reg <= byte_count_next;
            shift_reg      <= shift_next;
            dest_reg       <= dest_next;
            length_reg     <= length_next;
            ready_reg      <= ready_next;
        end
    end

    // byte count never runs past the saturation point
    a_byte_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= BYTE_COUNT_SAT)
        else $error("byte count past saturation");

    // a reported byte always comes from a data edge
    a_done_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        result.byte_done |-> result.data_edge)
        else $error("byte reported without data edge");

    // ready flag only falls on a clear item
    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && ready_reg && item.operation == OP_EDGE) |=> ready_reg)
        else $error("ready flag dropped without clear");

endmodule

`default_nettype wire

>>> rtl/manchester_frame_receiver_core.sv
// Top level of the Manchester frame receiver: input register, decode step,
// result register and configuration port. Depends on mfr_pkg, mfr_cfg_regs
// and mfr_bit_decoder.
`default_nettype none

// Each item (a timestamped line edge or a clear) gives exactly one result
// item. An item is registered on entry in the input register, decoded
// combinationally against the receiver state and held in the result
// register until it is taken, and a new item can be taken every cycle while
// the output is not stalled. A stall on the output holds the result register
// and then the input register; the input side stalls only when both are full.
// Configuration writes are always ready and should be issued only while no
// items are in flight.
module manchester_frame_receiver_core
    import mfr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  in_item_t                    in_item,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_item_t                   out_item,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t step_result;
    logic      step_fire;

    assign cfg_ready = 1'b1;

    mfr_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // handshake between stages
    assign step_fire = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !step_fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
    end

    mfr_bit_decoder u_bit_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_item_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // a decode step always leaves a result waiting
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> out_valid_reg)
        else $error("decode step lost its result");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !step_fire)
        else $error("result overwritten while stalled");

    // input only stalls with a held item that cannot move on
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without cause");

endmodule

`default_nettype wire
